/* rtl/slri_pkg.sv */
// sorted list store: shared types, codes and compare helpers
// used by slri_cell and sorted_list_insert_remove; no dependencies
package slri_pkg;

    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SORT,
        ST_APPLY
    } state_t;

    // control shared by every cell of the chain
    typedef struct packed {
        logic   do_insert;   // insert into a store that is not full
        logic   do_remove;   // remove, gated in the cell by the found flag
        logic   sort_step;   // one odd-even transposition pass
        logic   phase;       // which pairs take part in this pass
        logic   order_desc;  // order for inserts and sort passes
        logic   stored_desc; // order the store currently holds
        value_t value;
    } cell_ctrl_t;

    // a must not stand directly before b under the given order
    function automatic logic out_of_order(value_t a, value_t b, logic desc);
        logic res;
        if (desc)
        begin
            res = (a < b);
        end
        else
        begin
            res = (a > b);
        end
        return res;
    endfunction

endpackage

/* rtl/slri_cell.sv */
// one slot of the sorted chain: holds an entry and trades it with its neighbors
// depends on slri_pkg
module slri_cell (
    input  logic                clk,
    input  slri_pkg::cell_ctrl_t ctrl,
    input  logic                found,
    input  logic                occupied,
    input  logic                right_occupied,
    input  logic                odd_slot,
    input  logic                left_before,
    input  logic                left_swap,
    input  slri_pkg::value_t    left_entry,
    input  slri_pkg::value_t    right_entry,
    output slri_pkg::value_t    entry,
    output slri_pkg::value_t    entry_next,
    output logic                ahead,
    output logic                swap_low,
    output logic                match
);
    import slri_pkg::*;

    value_t entry_reg;
    value_t entry_next_c;
    logic   shift;

    always_comb
    begin
        ahead    = occupied && !out_of_order(entry_reg, ctrl.value, ctrl.order_desc);
        match    = occupied && (entry_reg == ctrl.value);
        swap_low = ctrl.sort_step && (odd_slot == ctrl.phase) && occupied
                   && right_occupied
                   && out_of_order(entry_reg, right_entry, ctrl.order_desc);
        // equal values sit together, so everything from the first match onward moves up
        shift    = found && occupied
                   && !out_of_order(ctrl.value, entry_reg, ctrl.stored_desc);
    end

    always_comb
    begin
        entry_next_c = entry_reg;
        if (ctrl.do_insert)
        begin
            if (!ahead)
            begin
                entry_next_c = left_before ? ctrl.value : left_entry;
            end
        end
        else if (ctrl.do_remove)
        begin
            if (shift)
            begin
                entry_next_c = right_entry;
            end
        end
        else if (swap_low)
        begin
            entry_next_c = right_entry;
        end
        else if (left_swap)
        begin
            entry_next_c = left_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next_c;
    end

    assign entry      = entry_reg;
    assign entry_next = entry_next_c;

endmodule

/* rtl/sorted_list_insert_remove.sv */
// sorted multiset store built as a chain of compare-and-shift cells
// depends on slri_pkg and slri_cell
//
//  channel  | signals                          | direction
//  ---------+----------------------------------+----------
//  in       | in_valid, in_ready, operation,   | input beat
//           | value                            |
//  out      | out_valid, out_ready, status,    | output beat
//           | element_count, front_value       |
//  cfg      | cfg_wr_en, cfg_wr_data           | register write
//
// one item at a time: the item is accepted in the idle state and applied in the apply state
// an insert into a store that is not full, after the order bit changed and with
// 2 or more values stored, first runs CAPACITY odd-even passes in the sort state
// the apply state waits while a finished result is not yet taken
// reset clears the count, the order bit and out_valid; entries are not cleared
module sorted_list_insert_remove #(
    parameter int CAPACITY = 16,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     operation,
    input  slri_pkg::value_t         value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [slri_pkg::STATUS_W-1:0] status,
    output logic [CNT_W-1:0]         element_count,
    output slri_pkg::value_t         front_value,
    input  logic                     cfg_wr_en,
    input  logic                     cfg_wr_data
);
    import slri_pkg::*;

    localparam int SORT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    state_t             state_reg, state_next;
    logic               op_reg;
    value_t             val_reg;
    logic               order_reg;
    logic               stored_desc_reg, stored_desc_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SORT_W-1:0]  sort_cnt_reg, sort_cnt_next;
    logic               out_valid_reg;
    status_t            status_reg, status_next;
    logic [CNT_W-1:0]   count_out_reg;
    value_t             front_reg, front_next;

    logic               accept;
    logic               apply;
    logic               sort_step;
    logic               full;
    logic               need_sort;
    logic               found;
    logic               sort_last;
    cell_ctrl_t         ctrl;

    value_t             entry_vec      [CAPACITY];
    value_t             entry_next_vec [CAPACITY];
    logic [CAPACITY-1:0] occupied_vec;
    logic [CAPACITY-1:0] before_vec;
    logic [CAPACITY-1:0] swap_vec;
    logic [CAPACITY-1:0] match_vec;

    assign full      = (count_reg >= CNT_W'(CAPACITY));
    assign sort_last = (sort_cnt_reg == SORT_W'(CAPACITY - 1));
    assign need_sort = (operation == OP_INSERT) && !full && (count_reg >= CNT_W'(2))
                       && (order_reg != stored_desc_reg);
    assign found     = |match_vec;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = need_sort ? ST_SORT : ST_APPLY;
                end
            end
            ST_SORT:
            begin
                if (sort_last)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready  = 1'b0;
        sort_step = 1'b0;
        apply     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_SORT:
            begin
                sort_step = 1'b1;
            end
            ST_APPLY:
            begin
                apply = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign accept = in_valid && in_ready;

    always_comb
    begin
        ctrl.do_insert   = apply && (op_reg == OP_INSERT) && !full;
        ctrl.do_remove   = apply && (op_reg == OP_REMOVE);
        ctrl.sort_step   = sort_step;
        ctrl.phase       = sort_cnt_reg[0];
        ctrl.order_desc  = order_reg;
        ctrl.stored_desc = stored_desc_reg;
        ctrl.value       = val_reg;
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic   left_before_w;
            logic   left_swap_w;
            logic   right_occ_w;
            value_t left_entry_w;
            value_t right_entry_w;

            assign occupied_vec[i] = (CNT_W'(i) < count_reg);

            if (i == 0)
            begin : g_head
                assign left_before_w = 1'b1;
                assign left_swap_w   = 1'b0;
                assign left_entry_w  = val_reg;
            end
            else
            begin : g_body
                assign left_before_w = before_vec[i-1];
                assign left_swap_w   = swap_vec[i-1];
                assign left_entry_w  = entry_vec[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign right_occ_w   = 1'b0;
                assign right_entry_w = '0;
            end
            else
            begin : g_next
                assign right_occ_w   = occupied_vec[i+1];
                assign right_entry_w = entry_vec[i+1];
            end

            slri_cell u_cell (
                .clk            (clk),
                .ctrl           (ctrl),
                .found          (found),
                .occupied       (occupied_vec[i]),
                .right_occupied (right_occ_w),
                .odd_slot       ((i % 2) == 1),
                .left_before    (left_before_w),
                .left_swap      (left_swap_w),
                .left_entry     (left_entry_w),
                .right_entry    (right_entry_w),
                .entry          (entry_vec[i]),
                .entry_next     (entry_next_vec[i]),
                .ahead          (before_vec[i]),
                .swap_low       (swap_vec[i]),
                .match          (match_vec[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next       = count_reg;
        stored_desc_next = stored_desc_reg;
        status_next      = STATUS_DONE;
        if (sort_step && sort_last)
        begin
            stored_desc_next = order_reg;
        end
        if (apply)
        begin
            if (op_reg == OP_INSERT)
            begin
                if (full)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    count_next       = count_reg + CNT_W'(1);
                    stored_desc_next = order_reg;
                end
            end
            else if (found)
            begin
                count_next = count_reg - CNT_W'(1);
            end
            else
            begin
                status_next = STATUS_NOT_FOUND;
            end
        end
        front_next = (count_next == '0) ? '0 : entry_next_vec[0];
    end

    always_comb
    begin
        sort_cnt_next = '0;
        if (sort_step)
        begin
            sort_cnt_next = sort_cnt_reg + SORT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            order_reg       <= 1'b0;
            stored_desc_reg <= 1'b0;
            count_reg       <= '0;
            sort_cnt_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            stored_desc_reg <= stored_desc_next;
            count_reg       <= count_next;
            sort_cnt_reg    <= sort_cnt_next;
            if (cfg_wr_en)
            begin
                order_reg <= cfg_wr_data;
            end
            if (apply)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= operation;
            val_reg <= value;
        end
        if (apply)
        begin
            status_reg    <= status_next;
            count_out_reg <= count_next;
            front_reg     <= front_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign element_count = count_out_reg;
    assign front_value   = front_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("new beat taken while an item is in flight");

    a_full_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        apply && (op_reg == OP_INSERT) && full |=> count_reg == $past(count_reg))
        else $error("dropped insert changed the count");

    a_sort_needs_pairs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SORT) |-> (count_reg >= CNT_W'(2)) && (op_reg == OP_INSERT))
        else $error("reorder pass without an insert or without pairs");

    a_empty_front: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (count_out_reg == '0) |-> front_reg == '0)
        else $error("empty store reports a front value");

endmodule
